// ----- design/hts_pkg.sv -----
// Shared types and constants of the HTML tag/text splitter.
// Holds the entity tables, the bracket codes and the step/result structs.
// No dependencies.
package hts_pkg;

	localparam int NUM_ENT  = 6;
	localparam int MAX_PEND = 5;
	localparam int MAX_RES  = 7;

	localparam logic [15:0] LT_CHAR  = 16'h003C;
	localparam logic [15:0] GT_CHAR  = 16'h003E;
	localparam logic [15:0] AMP_CHAR = 16'h0026;

	// entity spellings, padded with zeros to eight characters
	localparam logic [7:0] ENT_TEXT [NUM_ENT][8] = '{
		'{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B, 8'h00, 8'h00},  // &nbsp;
		'{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},  // &lt;
		'{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},  // &gt;
		'{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00, 8'h00},  // &quot;
		'{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B, 8'h00, 8'h00},  // &apos;
		'{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00, 8'h00}   // &amp;
	};
	localparam logic [3:0] ENT_LEN [NUM_ENT] = '{4'd6, 4'd4, 4'd4, 4'd6, 4'd6, 4'd5};
	localparam logic [15:0] ENT_VALUE [NUM_ENT] =
		'{16'h0020, 16'h003C, 16'h003E, 16'h0022, 16'h0027, 16'h0026};

	typedef struct packed {
		logic       tag_mode;
		logic       has_chars;
		logic [2:0] count;
	} state_t;

	typedef struct packed {
		logic [15:0] ch;
		logic        tag;
		logic        eoe;
		logic        last;
	} result_t;

	typedef struct packed {
		logic       en;
		logic [2:0] idx;
		logic [7:0] data;
	} pend_wr_t;

endpackage

// ----- design/hts_step.sv -----
// Per-request decode: entity matching, bracket handling and result assembly.
// Purely combinational; depends on hts_pkg.
module hts_step (
	input  logic                command,
	input  logic [15:0]         code_unit,
	input  hts_pkg::state_t     st,
	input  logic [7:0]          pend [hts_pkg::MAX_PEND],
	output hts_pkg::state_t     st_nxt,
	output hts_pkg::pend_wr_t   pwr,
	output logic [2:0]          res_cnt,
	output hts_pkg::result_t    res [hts_pkg::MAX_RES]
);
	import hts_pkg::*;

	logic             hit;
	logic             full;
	logic [2:0]       ent_idx;
	logic             flush;
	logic [1:0]       ne;
	result_t          ext [2];
	logic [2:0]       nf;
	logic [2:0]       n;

	assign n = st.count;

	// first entity that pending prefix plus this character still spells
	always_comb begin
		logic ok;
		hit = 1'b0;
		full = 1'b0;
		ent_idx = '0;
		for (int e = NUM_ENT - 1; e >= 0; e--) begin
			ok = (({1'b0, n} + 4'd1) <= ENT_LEN[e]);
			for (int i = 0; i < MAX_PEND; i++) begin
				if (i < int'(n) && pend[i] != ENT_TEXT[e][i])
					ok = 1'b0;
			end
			if (code_unit != {8'h00, ENT_TEXT[e][n]})
				ok = 1'b0;
			if (ok) begin
				hit = 1'b1;
				full = (({1'b0, n} + 4'd1) == ENT_LEN[e]);
				ent_idx = 3'(e);
			end
		end
	end

	always_comb begin
		flush = 1'b0;
		ne = 2'd0;
		ext[0] = '0;
		ext[1] = '0;
		st_nxt = st;
		pwr.en = 1'b0;
		pwr.idx = n;
		pwr.data = code_unit[7:0];
		if (command) begin
			flush = 1'b1;
			if (st.has_chars) begin
				ext[0] = '{ch: 16'h0000, tag: st.tag_mode, eoe: 1'b1, last: 1'b0};
				ne = 2'd1;
			end
			st_nxt = '0;
		end else if (code_unit == LT_CHAR) begin
			if (!st.tag_mode) begin
				flush = 1'b1;
				if (st.has_chars) begin
					ext[0] = '{ch: 16'h0000, tag: 1'b0, eoe: 1'b1, last: 1'b0};
					ext[1] = '{ch: LT_CHAR, tag: 1'b1, eoe: 1'b0, last: 1'b0};
					ne = 2'd2;
				end else begin
					ext[0] = '{ch: LT_CHAR, tag: 1'b1, eoe: 1'b0, last: 1'b0};
					ne = 2'd1;
				end
				st_nxt = '{tag_mode: 1'b1, has_chars: 1'b1, count: 3'd0};
			end
		end else if (code_unit == GT_CHAR) begin
			if (st.tag_mode) begin
				flush = 1'b1;
				ext[0] = '{ch: GT_CHAR, tag: 1'b1, eoe: 1'b0, last: 1'b0};
				ext[1] = '{ch: 16'h0000, tag: 1'b1, eoe: 1'b1, last: 1'b0};
				ne = 2'd2;
				st_nxt = '0;
			end
		end else begin
			st_nxt.has_chars = 1'b1;
			if (hit && full) begin
				ext[0] = '{ch: ENT_VALUE[ent_idx], tag: st.tag_mode, eoe: 1'b0, last: 1'b0};
				ne = 2'd1;
				st_nxt.count = 3'd0;
			end else if (hit && int'(n) < MAX_PEND) begin
				pwr.en = 1'b1;
				st_nxt.count = n + 3'd1;
			end else begin
				flush = 1'b1;
				if (code_unit == AMP_CHAR) begin
					pwr.en = 1'b1;
					pwr.idx = 3'd0;
					pwr.data = AMP_CHAR[7:0];
					st_nxt.count = 3'd1;
				end else begin
					ext[0] = '{ch: code_unit, tag: st.tag_mode, eoe: 1'b0, last: 1'b0};
					ne = 2'd1;
					st_nxt.count = 3'd0;
				end
			end
		end
	end

	assign nf = flush ? n : 3'd0;
	assign res_cnt = nf + {1'b0, ne};

	// pending literals first, then the extras, last flag on the final one
	always_comb begin
		logic [2:0] pos;
		for (int j = 0; j < MAX_RES; j++)
			res[j] = '0;
		for (int j = 0; j < MAX_PEND; j++) begin
			if (j < int'(nf))
				res[j] = '{ch: {8'h00, pend[j]}, tag: st.tag_mode, eoe: 1'b0, last: 1'b0};
		end
		for (int k = 0; k < 2; k++) begin
			pos = nf + 3'(k);
			if (k < int'(ne))
				res[pos] = ext[k];
		end
		for (int j = 0; j < MAX_RES; j++)
			res[j].last = (res_cnt != 3'd0) && (3'(j) == res_cnt - 3'd1);
	end

endmodule

// ----- design/hts_res_buf.sv -----
// Result buffer: loads all results of one request, shifts them out in order.
// Depends on hts_pkg.
module hts_res_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [2:0]        load_cnt,
	input  hts_pkg::result_t  load_res [hts_pkg::MAX_RES],
	output logic              can_load,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output hts_pkg::result_t  head
);
	import hts_pkg::*;

	logic [2:0] cnt_q;
	result_t    ent_q [MAX_RES];
	logic       take;

	assign rsp_valid = (cnt_q != 3'd0);
	assign take = rsp_valid && rsp_ready;
	// free now, or freed by the last entry leaving at this edge
	assign can_load = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && take);
	assign head = ent_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= load_cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= load_res;
		end else if (take) begin
			for (int i = 0; i < MAX_RES - 1; i++)
				ent_q[i] <= ent_q[i + 1];
		end
	end

endmodule

// ----- design/html_tag_text_splitter_core.sv -----
// Top level of the HTML tag/text splitter with entity decoding.
// Instantiates hts_step and hts_res_buf; depends on hts_pkg.
//
//   channel   | handshake              | payload
//   ----------+------------------------+------------------------------------------
//   request   | req_valid / req_ready  | command, code_unit
//   result    | rsp_valid / rsp_ready  | out_char, in_tag, element_end, last_of_run
//
// A request enters the input register; when the buffer can take them, its results
// (zero to seven) load the result buffer in a single step while the element state
// advances. Sustained rate is one request per cycle when each yields at most one
// result and results are not stalled; a request with N results holds the buffer
// until all N are taken, which sets the rate. Reset clears the element state and
// buffers; no clearing pass. Stalls on the result side hold the input register.
module html_tag_text_splitter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        command,
	input  logic [15:0] code_unit,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [15:0] out_char,
	output logic        in_tag,
	output logic        element_end,
	output logic        last_of_run
);
	import hts_pkg::*;

	// input register
	logic        valid_s1;
	logic        command_s1;
	logic [15:0] code_s1;

	// element state: tag flag, has-characters flag, pending prefix length
	state_t      state_q;
	logic [7:0]  pend_q [MAX_PEND];

	state_t      st_nxt;
	pend_wr_t    pwr;
	logic [2:0]  res_cnt;
	result_t     res [MAX_RES];
	logic        can_load;
	logic        fire;
	result_t     head;

	// process the held request once the result buffer can take its results
	assign fire = valid_s1 && can_load;
	assign req_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			command_s1 <= command;
			code_s1 <= code_unit;
		end
	end

	// advance element state only when a request is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= st_nxt;
		end
	end

	// pending entity characters; only entries below the count are ever read
	always_ff @(posedge clk) begin
		if (fire && pwr.en) begin
			pend_q[pwr.idx] <= pwr.data;
		end
	end

	hts_step u_step (
		.command   (command_s1),
		.code_unit (code_s1),
		.st        (state_q),
		.pend      (pend_q),
		.st_nxt    (st_nxt),
		.pwr       (pwr),
		.res_cnt   (res_cnt),
		.res       (res)
	);

	hts_res_buf u_res_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.load_cnt  (res_cnt),
		.load_res  (res),
		.can_load  (can_load),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.head      (head)
	);

	assign out_char = head.ch;
	assign in_tag = head.tag;
	assign element_end = head.eoe;
	assign last_of_run = head.last;

endmodule

// ----- dv/tb_html_tag_text_splitter_core.sv -----
// Self-checking testbench for html_tag_text_splitter_core: a directed table, then
// random HTML fragments, checked against a local tag/text and entity model.
// Depends on hts_pkg and the design sources.
module tb_html_tag_text_splitter_core;
	import hts_pkg::*;

	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam logic [15:0] SEMI_CHAR = 16'h003B;

	localparam int RESET_CYCLES    = 7;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int DRAIN_CYCLES    = 20;
	localparam int ITEMS_PER_PHASE = 32;
	localparam int NUM_PHASES      = 4;
	localparam int HOLD_CYCLES     = 300;
	localparam int MAX_PRINTS      = 40;
	localparam int DIR_ROWS        = 26;

	// Idle mix per random phase: none (with the long receiver hold), sender idle,
	// receiver stalling, both.
	localparam int SND_IDLE_PCT [NUM_PHASES] = '{0, 75, 0, 35};
	localparam int RCV_STALL_PCT [NUM_PHASES] = '{0, 0, 75, 35};

	typedef enum logic [1:0] {MK_NONE, MK_PREFIX, MK_FULL} match_e;

	// Fragment shapes of the random part; the first three are the common ones.
	typedef enum logic [2:0] {
		FR_ENTITY, FR_TEXT, FR_TAG, FR_BROKEN, FR_LONG_TAG, FR_STRAY, FR_NOISE, FR_END
	} frag_e;

	// One request of the directed table. With fixed set, n_fixed results typed
	// in r0/r1 replace what the model predicts (the model still advances).
	typedef struct packed {
		logic        cmd;
		logic [15:0] cu;
		logic        fixed;
		logic [1:0]  n_fixed;
		result_t     r0;
		result_t     r1;
	} stim_row_t;

	localparam result_t NO_RES = '0;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic        command;
	logic [15:0] code_unit;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [15:0] out_char;
	logic        in_tag;
	logic        element_end;
	logic        last_of_run;

	// Model of the splitter state.
	logic        tag_open;
	logic        elem_has_chars;
	logic [7:0]  ent_buf [MAX_PEND];
	int          ent_cnt;
	result_t     step_out [$];

	// Results owed by the block, oldest first.
	result_t     owed_results [$];

	stim_row_t   dir_tab [DIR_ROWS];
	result_t     want;
	logic        rsp_hold;
	int          snd_idle_pct;
	int          rcv_stall_pct;
	int          cycle_cnt = 0;
	int          n_errors = 0;
	int          n_reqs = 0;
	int          n_checked = 0;
	int          n_markers = 0;
	int          max_burst = 0;

	html_tag_text_splitter_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.command     (command),
		.code_unit   (code_unit),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.out_char    (out_char),
		.in_tag      (in_tag),
		.element_end (element_end),
		.last_of_run (last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Splitter model
	// ------------------------------------------------------------------

	function automatic void emit_res(logic [15:0] ch, logic tg, logic eoe);
		result_t r;
		r.ch   = ch;
		r.tag  = tg;
		r.eoe  = eoe;
		r.last = 1'b0;
		step_out.push_back(r);
	endfunction

	// Dump a partly matched entity as literal characters.
	function automatic void spill_entity();
		for (int i = 0; i < ent_cnt; i++)
			emit_res({8'h00, ent_buf[i]}, tag_open, 1'b0);
		ent_cnt = 0;
	endfunction

	// Does the held prefix plus c start or complete an entity? First hit wins.
	function automatic match_e match_entity(logic [15:0] c, output int which);
		which = 0;
		for (int e = 0; e < NUM_ENT; e++) begin
			logic ok;
			if (ent_cnt + 1 > int'(ENT_LEN[e]))
				continue;
			ok = 1'b1;
			for (int i = 0; i < ent_cnt; i++)
				if (ent_buf[i] != ENT_TEXT[e][i])
					ok = 1'b0;
			if (!ok || c != {8'h00, ENT_TEXT[e][ent_cnt]})
				continue;
			which = e;
			if (ent_cnt + 1 == int'(ENT_LEN[e]))
				return MK_FULL;
			return MK_PREFIX;
		end
		return MK_NONE;
	endfunction

	function automatic void take_char(logic [15:0] c);
		int     which;
		match_e kind;
		elem_has_chars = 1'b1;
		kind = match_entity(c, which);
		if (kind == MK_FULL) begin
			ent_cnt = 0;
			emit_res(ENT_VALUE[which], tag_open, 1'b0);
		end else if (kind == MK_PREFIX && ent_cnt < MAX_PEND) begin
			ent_buf[ent_cnt] = c[7:0];
			ent_cnt++;
		end else begin
			// broken entity: flush it, then a fresh '&' starts a new prefix
			spill_entity();
			if (c == AMP_CHAR) begin
				ent_buf[0] = AMP_CHAR[7:0];
				ent_cnt = 1;
			end else begin
				emit_res(c, tag_open, 1'b0);
			end
		end
	endfunction

	// Advance the model by one request; its results land in step_out.
	function automatic void split_and_decode(logic cmd, logic [15:0] c);
		step_out.delete();
		if (cmd == CMD_END) begin
			spill_entity();
			if (elem_has_chars)
				emit_res(16'h0000, tag_open, 1'b1);
			tag_open = 1'b0;
			elem_has_chars = 1'b0;
		end else if (c == LT_CHAR) begin
			// a '<' inside a tag is dropped
			if (!tag_open) begin
				spill_entity();
				if (elem_has_chars)
					emit_res(16'h0000, 1'b0, 1'b1);
				tag_open = 1'b1;
				elem_has_chars = 1'b0;
				take_char(c);
			end
		end else if (c == GT_CHAR) begin
			// a '>' outside a tag is dropped
			if (tag_open) begin
				take_char(c);
				spill_entity();
				emit_res(16'h0000, 1'b1, 1'b1);
				tag_open = 1'b0;
				elem_has_chars = 1'b0;
			end
		end else begin
			take_char(c);
		end
		if (step_out.size() > 0)
			step_out[step_out.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	function automatic stim_row_t row(logic cmd, logic [15:0] cu);
		stim_row_t s;
		s = '0;
		s.cmd = cmd;
		s.cu  = cu;
		return s;
	endfunction

	function automatic stim_row_t fixed_row(logic cmd, logic [15:0] cu, int n,
			result_t r0, result_t r1);
		stim_row_t s;
		s = row(cmd, cu);
		s.fixed   = 1'b1;
		s.n_fixed = 2'(n);
		s.r0      = r0;
		s.r1      = r1;
		return s;
	endfunction

	// Offer one request, hold it until accepted, then book its results.
	task automatic send_req(input stim_row_t s);
		if ($urandom_range(0, 99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
		end
		req_valid <= 1'b1;
		command   <= s.cmd;
		code_unit <= s.cu;
		do @(posedge clk); while (!req_ready);

		split_and_decode(s.cmd, s.cu);
		n_reqs++;
		if (step_out.size() > max_burst)
			max_burst = step_out.size();
		foreach (step_out[i])
			if (step_out[i].eoe)
				n_markers++;
		if (s.fixed) begin
			if (s.n_fixed > 0)
				owed_results.push_back(s.r0);
			if (s.n_fixed > 1)
				owed_results.push_back(s.r1);
		end else begin
			foreach (step_out[i])
				owed_results.push_back(step_out[i]);
		end
	endtask

	// Random HTML fragments, mostly well formed, some broken, some noise.
	task automatic send_random(input int n_items);
		int          done_items;
		int          pick;
		int          e;
		int          plen;
		frag_e       kind;
		logic [16:0] frag [$];
		done_items = 0;
		while (done_items < n_items) begin
			frag.delete();
			pick = $urandom_range(0, 11);
			// weight: entity 3, tag 2, text 2, each remaining shape 1
			if (pick < 3)
				kind = FR_ENTITY;
			else if (pick < 5)
				kind = FR_TAG;
			else if (pick < 7)
				kind = FR_TEXT;
			else
				kind = frag_e'(pick - 4);
			e = $urandom_range(0, NUM_ENT - 1);
			case (kind)
				FR_ENTITY: begin
					for (int i = 0; i < ENT_LEN[e]; i++)
						frag.push_back({CMD_CHAR, 8'h00, ENT_TEXT[e][i]});
				end
				FR_TEXT: begin
					repeat ($urandom_range(1, 3))
						frag.push_back({CMD_CHAR, 16'(16'h0020 + $urandom_range(0, 94))});
				end
				FR_TAG: begin
					frag.push_back({CMD_CHAR, LT_CHAR});
					repeat ($urandom_range(1, 3))
						frag.push_back({CMD_CHAR, 16'(16'h0061 + $urandom_range(0, 25))});
					if ($urandom_range(0, 1))
						for (int i = 0; i < ENT_LEN[e]; i++)
							frag.push_back({CMD_CHAR, 8'h00, ENT_TEXT[e][i]});
					frag.push_back({CMD_CHAR, GT_CHAR});
				end
				FR_BROKEN: begin
					plen = $urandom_range(1, int'(ENT_LEN[e]) - 1);
					for (int i = 0; i < plen; i++)
						frag.push_back({CMD_CHAR, 8'h00, ENT_TEXT[e][i]});
					case ($urandom_range(0, 5))
						0: frag.push_back({CMD_CHAR, 16'(16'h0061 + $urandom_range(0, 25))});
						1: frag.push_back({CMD_CHAR, AMP_CHAR});
						2: frag.push_back({CMD_CHAR, LT_CHAR});
						3: frag.push_back({CMD_CHAR, GT_CHAR});
						4: frag.push_back({CMD_CHAR, 16'($urandom_range(0, 65535))});
						default: frag.push_back({CMD_END, 16'($urandom_range(0, 65535))});
					endcase
				end
				FR_LONG_TAG: begin
					// five held entity characters, then '>': the largest burst
					if ($urandom_range(0, 2) == 0)
						e = 0;
					else
						e = 2 + $urandom_range(1, 2);
					frag.push_back({CMD_CHAR, LT_CHAR});
					for (int i = 0; i < MAX_PEND; i++)
						frag.push_back({CMD_CHAR, 8'h00, ENT_TEXT[e][i]});
					frag.push_back({CMD_CHAR, GT_CHAR});
				end
				FR_STRAY: begin
					frag.push_back({CMD_CHAR, $urandom_range(0, 1) ? LT_CHAR : GT_CHAR});
				end
				FR_NOISE: begin
					frag.push_back({CMD_CHAR, 16'($urandom_range(0, 65535))});
				end
				default: begin
					frag.push_back({CMD_END, 16'($urandom_range(0, 65535))});
				end
			endcase
			foreach (frag[i])
				send_req(row(frag[i][16], frag[i][15:0]));
			if (kind != FR_STRAY)
				done_items += frag.size();
		end
	endtask

	// Stall the result side for a fixed stretch while requests keep coming.
	task automatic hold_results(input int n_cycles);
		rsp_hold <= 1'b1;
		repeat (n_cycles) @(posedge clk);
		rsp_hold <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: ready, checking, watchdog
	// ------------------------------------------------------------------

	always @(posedge clk)
		rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= rcv_stall_pct);

	task automatic report(input string what);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("[cycle %0d] mismatch: %s", cycle_cnt, what);
	endtask

	// Compare each accepted result with the oldest owed one, field by field.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (owed_results.size() == 0) begin
				report($sformatf("result %h tag %b end %b last %b with none owed",
					out_char, in_tag, element_end, last_of_run));
			end else begin
				want = owed_results.pop_front();
				n_checked++;
				if (out_char !== want.ch)
					report($sformatf("out_char %h, want %h", out_char, want.ch));
				if (in_tag !== want.tag)
					report($sformatf("in_tag %b, want %b", in_tag, want.tag));
				if (element_end !== want.eoe)
					report($sformatf("element_end %b, want %b", element_end, want.eoe));
				if (last_of_run !== want.last)
					report($sformatf("last_of_run %b, want %b", last_of_run, want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout: %0d results still owed", owed_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		command       = CMD_CHAR;
		code_unit     = 16'h0000;
		rsp_ready     = 1'b0;
		rsp_hold      = 1'b0;
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;

		tag_open       = 1'b0;
		elem_has_chars = 1'b0;
		ent_cnt        = 0;
		foreach (ent_buf[i])
			ent_buf[i] = 8'h00;

		dir_tab = '{
			// plain character straight after reset
			fixed_row(CMD_CHAR, 16'h0041, 1, result_t'{16'h0041, 1'b0, 1'b0, 1'b1}, NO_RES),
			// stray '>' outside a tag: nothing
			fixed_row(CMD_CHAR, GT_CHAR, 0, NO_RES, NO_RES),
			// code unit extremes pass through as text
			fixed_row(CMD_CHAR, 16'hFFFF, 1, result_t'{16'hFFFF, 1'b0, 1'b0, 1'b1}, NO_RES),
			fixed_row(CMD_CHAR, 16'h0000, 1, result_t'{16'h0000, 1'b0, 1'b0, 1'b1}, NO_RES),
			// &lt; decodes to '<'
			row(CMD_CHAR, AMP_CHAR), row(CMD_CHAR, 16'h006C), row(CMD_CHAR, 16'h0074),
			row(CMD_CHAR, SEMI_CHAR),
			// broken entity "&nbx" comes out literally
			row(CMD_CHAR, AMP_CHAR), row(CMD_CHAR, 16'h006E), row(CMD_CHAR, 16'h0062),
			row(CMD_CHAR, 16'h0078),
			// held '&' flushed as text, marker, then the tag opens
			row(CMD_CHAR, AMP_CHAR), row(CMD_CHAR, LT_CHAR),
			// stray '<' inside a tag: nothing
			fixed_row(CMD_CHAR, LT_CHAR, 0, NO_RES, NO_RES),
			// "&g" then '>' closes the tag with the prefix flushed
			row(CMD_CHAR, AMP_CHAR), row(CMD_CHAR, 16'h0067), row(CMD_CHAR, GT_CHAR),
			// '<' after an empty text element: no marker
			fixed_row(CMD_CHAR, LT_CHAR, 1, result_t'{LT_CHAR, 1'b1, 1'b0, 1'b1}, NO_RES),
			// end of document inside a tag with a prefix held
			row(CMD_CHAR, AMP_CHAR), row(CMD_CHAR, 16'h0071), row(CMD_END, 16'hFFFF),
			// end of an empty document: nothing
			fixed_row(CMD_END, 16'h0000, 0, NO_RES, NO_RES),
			// '&' after '&' restarts the prefix, end flushes it
			row(CMD_CHAR, AMP_CHAR), row(CMD_CHAR, AMP_CHAR), row(CMD_END, 16'h0000)
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_req(dir_tab[i]);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			snd_idle_pct  = SND_IDLE_PCT[ph];
			rcv_stall_pct <= RCV_STALL_PCT[ph];
			if (ph == 0) begin
				// back up the result side so the block fills and stalls requests
				fork
					hold_results(HOLD_CYCLES);
					send_random(ITEMS_PER_PHASE);
				join
			end else begin
				send_random(ITEMS_PER_PHASE);
			end
		end
		req_valid <= 1'b0;

		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests (%0d directed) under four idle mixes and a long hold.",
			n_reqs, DIR_ROWS);
		$display("Checked %0d results, %0d element markers, largest burst %0d.",
			n_checked, n_markers, max_burst);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/hts_pkg.sv
design/hts_step.sv
design/hts_res_buf.sv
design/html_tag_text_splitter_core.sv
dv/tb_html_tag_text_splitter_core.sv
